// ===== rtl/core/granular_grain_player_macros.svh =====
// assertion macros for the grain player
// each macro takes a label, the clock, the reset and two expressions
`ifndef GRANULAR_GRAIN_PLAYER_MACROS_SVH
`define GRANULAR_GRAIN_PLAYER_MACROS_SVH
`ifndef SYNTHESIS
// consequent holds in the same cycle
`define GGP_ASSERT_SAME(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("grain player check failed: same cycle");
// consequent holds in the next cycle
`define GGP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("grain player check failed: next cycle");
`else
`define GGP_ASSERT_SAME(label, clk, rst, lhs, rhs)
`define GGP_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

// ===== rtl/core/ggp_pkg.sv =====
package ggp_pkg;

   // store and sample geometry
   localparam int StoreDepth    = 65536;
   localparam int AddrBits      = $clog2(StoreDepth);
   localparam int SampleBits    = 16;
   localparam int InAddrBits    = 16;

   // window table geometry, window is unsigned q1.16 up to one
   localparam int CosTableDepth = 256;
   localparam int CosIdxBits    = $clog2(CosTableDepth);
   localparam int WindowBits    = 17;
   localparam int WindowFrac    = 16;

   // product of sample and window, window carried with a sign bit
   localparam int ProductBits   = SampleBits + WindowBits + 1;

   // configuration widths and reset values
   localparam int LengthBits    = 16;
   localparam int ClipBits      = 17;
   localparam int LfsrBits      = 16;
   localparam int CsrIndexBits  = 2;
   localparam int CsrDataBits   = 17;
   localparam logic [LengthBits-1:0] GrainLengthReset = 16'd1024;
   localparam logic [ClipBits-1:0]   ClipLengthReset  = 17'd65536;
   localparam logic [LfsrBits-1:0]   RandomSeedReset  = 16'd44257;
   localparam logic [LfsrBits-1:0]   LfsrMask         = 16'hB400;

   // register indexes
   localparam logic [CsrIndexBits-1:0] RegGrainLength = 2'd0;
   localparam logic [CsrIndexBits-1:0] RegClipLength  = 2'd1;
   localparam logic [CsrIndexBits-1:0] RegRandomSeed  = 2'd2;

   // request word action codes
   localparam logic ActionWrite = 1'b0;
   localparam logic ActionTick  = 1'b1;

   // divider step counter holds up to the widest dividend
   localparam int DivStepBits   = $clog2(LfsrBits + 1);

   // fixed point constants for the cosine series
   localparam longint PiHalfQ30 = 64'sd1686629713;
   localparam longint OneQ30    = 64'sd1073741824;
   localparam longint OneQ16    = 64'sd65536;

   // controller to datapath commands
   typedef struct packed {
      logic store_write;
      logic tick_start;
      logic window_load;
      logic product_load;
      logic result_load;
   } ggp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_busy;
      logic div_done;
   } ggp_status_type;

   typedef logic [WindowBits-1:0] window_table_type [CosTableDepth];

   // hann window entry: (1 - cos(2 pi i / depth)) / 2 in unsigned q1.16
   function automatic logic [WindowBits-1:0] window_value(int unsigned idx);
      longint n;
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint c;
      logic   neg;
      n   = 4 * longint'(idx);
      neg = 1'b0;
      // fold the angle into one quarter wave
      if (n > 2 * CosTableDepth) n = 4 * CosTableDepth - n;
      if (n > CosTableDepth) begin
         neg = 1'b1;
         n   = 2 * CosTableDepth - n;
      end
      x    = (PiHalfQ30 * n) / CosTableDepth;
      x2   = (x * x) >>> 30;
      term = OneQ30;
      sum  = OneQ30;
      // taylor series of cosine, the constant term and seven more
      for (int k = 1; k <= 7; k++) begin
         term = (term * x2) >>> 30;
         case (k)
            1:       term = term / 2;
            2:       term = term / 12;
            3:       term = term / 30;
            4:       term = term / 56;
            5:       term = term / 90;
            6:       term = term / 132;
            default: term = term / 182;
         endcase
         if ((k & 1) != 0) sum = sum - term;
         else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      sum = (sum + 64'sd8192) >>> 14;
      if (sum > OneQ16) sum = OneQ16;
      c = neg ? -sum : sum;
      return WindowBits'((OneQ16 - c) >>> 1);
   endfunction

   function automatic window_table_type build_window_table();
      window_table_type t;
      for (int i = 0; i < CosTableDepth; i++) begin
         t[i] = window_value(i);
      end
      return t;
   endfunction

   localparam window_table_type WindowTable = build_window_table();

endpackage

// ===== rtl/core/ggp_divider.sv =====
module ggp_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ggp_pkg::LfsrBits-1:0]      init_rem,
   input  logic [ggp_pkg::LfsrBits-1:0]      dividend,
   input  logic [ggp_pkg::DivStepBits-1:0]   steps,
   input  logic [ggp_pkg::ClipBits-1:0]      divisor,
   output logic                              busy,
   output logic                              done,
   output logic [ggp_pkg::LfsrBits-1:0]      quotient,
   output logic [ggp_pkg::LfsrBits-1:0]      remainder
);

   logic [ggp_pkg::LfsrBits-1:0]    rem_ff, rem_in;
   logic [ggp_pkg::LfsrBits-1:0]    dvd_ff, dvd_in;
   logic [ggp_pkg::LfsrBits-1:0]    quo_ff, quo_in;
   logic [ggp_pkg::ClipBits-1:0]    dsr_ff, dsr_in;
   logic [ggp_pkg::DivStepBits-1:0] count_ff, count_in;
   logic                            done_ff, done_in;
   logic [ggp_pkg::ClipBits-1:0]    rem_shift;
   logic [ggp_pkg::ClipBits-1:0]    rem_sub;
   logic                            fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, dvd_ff[ggp_pkg::LfsrBits-1]};
   assign fits      = (rem_shift >= dsr_ff);
   assign rem_sub   = rem_shift - dsr_ff;

   always_comb begin
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = init_rem;
         dvd_in   = dividend;
         quo_in   = '0;
         dsr_in   = divisor;
         count_in = steps;
      end else if (count_ff != '0) begin
         rem_in   = fits ? rem_sub[ggp_pkg::LfsrBits-1:0] : rem_shift[ggp_pkg::LfsrBits-1:0];
         dvd_in   = {dvd_ff[ggp_pkg::LfsrBits-2:0], 1'b0};
         quo_in   = {quo_ff[ggp_pkg::LfsrBits-2:0], fits};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == ggp_pkg::DivStepBits'(1));
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = (count_ff != '0);
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/ggp_datapath.sv =====
module ggp_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  ggp_pkg::ggp_cmd_type                     cmd,
   output ggp_pkg::ggp_status_type                  status,
   input  logic [ggp_pkg::InAddrBits-1:0]           req_write_address,
   input  logic signed [ggp_pkg::SampleBits-1:0]    req_write_value,
   input  logic                                     csr_write_enable,
   input  logic [ggp_pkg::CsrIndexBits-1:0]         csr_index,
   input  logic [ggp_pkg::CsrDataBits-1:0]          csr_write_data,
   output logic signed [ggp_pkg::SampleBits-1:0]    rsp_sample_out,
   output logic                                     rsp_grain_restart
);

   localparam int ScaledBits = ggp_pkg::ProductBits - ggp_pkg::WindowFrac;
   localparam logic signed [ScaledBits-1:0] ScaledMax =
      ScaledBits'((longint'(1) << (ggp_pkg::SampleBits - 1)) - 1);
   localparam logic signed [ScaledBits-1:0] ScaledMin =
      ScaledBits'(-(longint'(1) << (ggp_pkg::SampleBits - 1)));
   localparam logic [ggp_pkg::ProductBits-1:0] RoundHalf =
      ggp_pkg::ProductBits'(longint'(1) << (ggp_pkg::WindowFrac - 1));

   logic signed [ggp_pkg::SampleBits-1:0] store_mem [ggp_pkg::StoreDepth];

   logic [ggp_pkg::LengthBits-1:0]        glen_ff, glen_in;
   logic [ggp_pkg::ClipBits-1:0]          clip_ff, clip_in;
   logic [ggp_pkg::LfsrBits-1:0]          lfsr_ff, lfsr_in;
   logic [ggp_pkg::LengthBits-1:0]        pos_ff, pos_in;
   logic [ggp_pkg::LengthBits-1:0]        start_ff, start_in;
   logic                                  restart_ff;
   logic                                  span_ok_ff;
   logic signed [ggp_pkg::SampleBits-1:0] rd_data_ff;
   logic [ggp_pkg::WindowBits-1:0]        window_ff;
   logic signed [ggp_pkg::ProductBits-1:0] product_ff;
   logic signed [ggp_pkg::SampleBits-1:0] sample_ff;
   logic                                  grain_restart_ff;

   logic [ggp_pkg::LfsrBits-1:0]          lfsr_step;
   logic [ggp_pkg::LfsrBits-1:0]          seed_value;
   logic                                  restart_now;
   logic                                  span_ok;
   logic [ggp_pkg::ClipBits-1:0]          span;
   logic [ggp_pkg::AddrBits-1:0]          rd_addr;
   logic [ggp_pkg::LfsrBits-1:0]          div_init_rem;
   logic [ggp_pkg::LfsrBits-1:0]          div_dividend;
   logic [ggp_pkg::DivStepBits-1:0]       div_steps;
   logic [ggp_pkg::ClipBits-1:0]          div_divisor;
   logic [ggp_pkg::LfsrBits-1:0]          div_quotient;
   logic [ggp_pkg::LfsrBits-1:0]          div_remainder;
   logic [ggp_pkg::ProductBits-1:0]       rounded_sum;
   logic signed [ScaledBits-1:0]          scaled;
   logic signed [ggp_pkg::SampleBits-1:0] saturated;

   // galois lfsr, shifted right
   assign lfsr_step = {1'b0, lfsr_ff[ggp_pkg::LfsrBits-1:1]}
                      ^ (lfsr_ff[0] ? ggp_pkg::LfsrMask : '0);

   // a zero seed would lock the lfsr
   assign seed_value = (csr_write_data[ggp_pkg::LfsrBits-1:0] == '0)
                       ? ggp_pkg::LfsrBits'(1) : csr_write_data[ggp_pkg::LfsrBits-1:0];

   assign restart_now = (pos_ff >= glen_ff);
   assign span_ok     = (clip_ff > {1'b0, glen_ff});
   assign span        = clip_ff - {1'b0, glen_ff};
   assign rd_addr     = ggp_pkg::AddrBits'(start_ff + pos_ff);

   // divider set-up: start modulo span on restart, window index otherwise
   always_comb begin
      if (restart_now) begin
         div_init_rem = '0;
         div_dividend = lfsr_step;
         div_steps    = ggp_pkg::DivStepBits'(ggp_pkg::LfsrBits);
         div_divisor  = span_ok ? span : ggp_pkg::ClipBits'(1);
      end else begin
         div_init_rem = pos_ff;
         div_dividend = '0;
         div_steps    = ggp_pkg::DivStepBits'(ggp_pkg::CosIdxBits);
         div_divisor  = {1'b0, glen_ff};
      end
   end

   ggp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.tick_start),
      .init_rem  (div_init_rem),
      .dividend  (div_dividend),
      .steps     (div_steps),
      .divisor   (div_divisor),
      .busy      (status.div_busy),
      .done      (status.div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // configuration, lfsr and grain state
   always_comb begin
      glen_in  = glen_ff;
      clip_in  = clip_ff;
      lfsr_in  = lfsr_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      if (cmd.tick_start && restart_now) lfsr_in = lfsr_step;
      if (cmd.result_load) begin
         if (restart_ff) begin
            pos_in   = '0;
            start_in = span_ok_ff ? div_remainder : '0;
         end else begin
            pos_in   = pos_ff + 1'b1;
         end
      end
      if (csr_write_enable) begin
         unique case (csr_index)
            ggp_pkg::RegGrainLength: glen_in = csr_write_data[ggp_pkg::LengthBits-1:0];
            ggp_pkg::RegClipLength:  clip_in = csr_write_data;
            ggp_pkg::RegRandomSeed:  lfsr_in = seed_value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glen_ff  <= ggp_pkg::GrainLengthReset;
         clip_ff  <= ggp_pkg::ClipLengthReset;
         lfsr_ff  <= ggp_pkg::RandomSeedReset;
         pos_ff   <= ggp_pkg::GrainLengthReset;
         start_ff <= '0;
      end else begin
         glen_ff  <= glen_in;
         clip_ff  <= clip_in;
         lfsr_ff  <= lfsr_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
      end
   end

   // sample store write port
   always_ff @(posedge clock) begin
      if (cmd.store_write) begin
         store_mem[req_write_address[ggp_pkg::AddrBits-1:0]] <= req_write_value;
      end
   end

   // sample store read port, registered
   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // per-tick flags
   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         restart_ff <= restart_now;
         span_ok_ff <= span_ok;
      end
   end

   // window lookup, then multiply
   always_ff @(posedge clock) begin
      if (cmd.window_load) begin
         window_ff <= ggp_pkg::WindowTable[div_quotient[ggp_pkg::CosIdxBits-1:0]];
      end
      if (cmd.product_load) begin
         product_ff <= rd_data_ff * $signed({1'b0, window_ff});
      end
   end

   // round half up, drop the fraction, saturate
   assign rounded_sum = product_ff + RoundHalf;
   assign scaled      = $signed(rounded_sum[ggp_pkg::ProductBits-1:ggp_pkg::WindowFrac]);

   always_comb begin
      if (scaled > ScaledMax) begin
         saturated = ScaledMax[ggp_pkg::SampleBits-1:0];
      end else if (scaled < ScaledMin) begin
         saturated = ScaledMin[ggp_pkg::SampleBits-1:0];
      end else begin
         saturated = scaled[ggp_pkg::SampleBits-1:0];
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         sample_ff        <= restart_ff ? '0 : saturated;
         grain_restart_ff <= restart_ff;
      end
   end

   assign rsp_sample_out    = sample_ff;
   assign rsp_grain_restart = grain_restart_ff;

endmodule

// ===== rtl/core/ggp_ctrl.sv =====
module ggp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ggp_pkg::ggp_status_type status,
   output ggp_pkg::ggp_cmd_type    cmd
);

   localparam logic [2:0] StIdle     = 3'd0;
   localparam logic [2:0] StDivide   = 3'd1;
   localparam logic [2:0] StWindow   = 3'd2;
   localparam logic [2:0] StMultiply = 3'd3;
   localparam logic [2:0] StResult   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   logic       slot_free;

   assign req_ready = (state_ff == StIdle);
   assign req_take  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_take) begin
               if (req_action == ggp_pkg::ActionWrite) begin
                  cmd.store_write = 1'b1;
               end else begin
                  cmd.tick_start = 1'b1;
                  state_in       = StDivide;
               end
            end
         end
         StDivide: begin
            if (status.div_done) state_in = StWindow;
         end
         StWindow: begin
            cmd.window_load = 1'b1;
            state_in        = StMultiply;
         end
         StMultiply: begin
            cmd.product_load = 1'b1;
            state_in         = StResult;
         end
         StResult: begin
            if (slot_free) begin
               cmd.result_load = 1'b1;
               state_in        = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // output word valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/granular_grain_player.sv =====
// channel   direction  words                              handshake
// req       in         action, write address, write value valid / ready
// rsp       out        sample out, grain restart          valid / ready
// csr       in         index, write data                  write enable only
//
// a store write is done in the cycle that accepts it. a tick steps through the
// divide, window, multiply and result states: the shared divider retires one
// bit a cycle, 8 bits for the window index and 16 for the start modulo.
// reset is synchronous; the sample store is not cleared and needs no sweep.
// a tick waits in its last state while the output word is still held.
`include "granular_grain_player_macros.svh"

module granular_grain_player (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_action,
   input  logic [ggp_pkg::InAddrBits-1:0]          req_write_address,
   input  logic signed [ggp_pkg::SampleBits-1:0]   req_write_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [ggp_pkg::SampleBits-1:0]   rsp_sample_out,
   output logic                                    rsp_grain_restart,
   input  logic                                    csr_write_enable,
   input  logic [ggp_pkg::CsrIndexBits-1:0]        csr_index,
   input  logic [ggp_pkg::CsrDataBits-1:0]         csr_write_data
);

   ggp_pkg::ggp_cmd_type    cmd;
   ggp_pkg::ggp_status_type status;

   ggp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   ggp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_write_address (req_write_address),
      .req_write_value   (req_write_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_grain_restart (rsp_grain_restart)
   );

   // checks
   `GGP_ASSERT_SAME(a_ready_div_idle, clock, reset, req_ready, !status.div_busy)
   `GGP_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.result_load, !rsp_valid || rsp_ready)
   `GGP_ASSERT_SAME(a_restart_zero, clock, reset, rsp_valid && rsp_grain_restart, rsp_sample_out == '0)
   `GGP_ASSERT_NEXT(a_load_shows, clock, reset, cmd.result_load, rsp_valid)

endmodule
